// ----- src/dps_pkg.sv -----
// Package for the dynamic priority scheduler.
// Holds field widths, request and status codes, and the chain command type.
// No dependencies.
`default_nettype none

package dps_pkg;

  localparam int ID_W     = 4;
  localparam int PRIO_W   = 8;
  localparam int NEED_W   = 8;
  localparam int USED_W   = 8;
  localparam int STATUS_W = 2;

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_RUN = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ADDED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RAN      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IDLE     = 2'd3;

  localparam logic signed [PRIO_W-1:0] PRIO_MIN = 8'sh80;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;

  typedef struct packed {
    logic [1:0]               op;
    logic [ID_W-1:0]          id;
    logic signed [PRIO_W-1:0] prio;
  } chain_cmd_t;

endpackage

`default_nettype wire

// ----- src/dps_req_if.sv -----
// Request channel of the dynamic priority scheduler: valid, ready and payload.
// Depends on dps_pkg.
`default_nettype none

interface dps_req_if;
  import dps_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [ID_W-1:0]          task_id;
  logic signed [PRIO_W-1:0] priority_req;
  logic [NEED_W-1:0]        need_slices;

  modport source (output valid, req_type, task_id, priority_req, need_slices, input ready);
  modport sink   (input valid, req_type, task_id, priority_req, need_slices, output ready);
endinterface

`default_nettype wire

// ----- src/dps_rsp_if.sv -----
// Result channel of the dynamic priority scheduler: valid, ready and payload.
// Depends on dps_pkg; QLEN_W must equal $clog2(MAX_TASKS + 1) of the scheduler.
`default_nettype none

interface dps_rsp_if #(
  parameter int QLEN_W = 5
);
  import dps_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [ID_W-1:0]          ran_id;
  logic signed [PRIO_W-1:0] ran_priority;
  logic [USED_W-1:0]        used_slices;
  logic                     finished;
  logic [QLEN_W-1:0]        queue_length;

  modport source (output valid, status, ran_id, ran_priority, used_slices, finished,
                  queue_length, input ready);
  modport sink   (input valid, status, ran_id, ran_priority, used_slices, finished,
                  queue_length, output ready);
endinterface

`default_nettype wire

// ----- src/dps_cell.sv -----
// One cell of the sorted ready chain: holds one task and shifts with its neighbors.
// Depends on dps_pkg.
`default_nettype none

module dps_cell #(
  parameter int SLICE_BITS = 8
) (
  input  wire                              clk,
  input  wire dps_pkg::chain_cmd_t         cmd,
  input  wire [SLICE_BITS-1:0]             cmd_need,
  input  wire [SLICE_BITS-1:0]             cmd_used,
  input  wire                              occ,
  input  wire                              prev_ge,
  input  wire [dps_pkg::ID_W-1:0]          prev_id,
  input  wire signed [dps_pkg::PRIO_W-1:0] prev_prio,
  input  wire [SLICE_BITS-1:0]             prev_need,
  input  wire [SLICE_BITS-1:0]             prev_used,
  input  wire [dps_pkg::ID_W-1:0]          next_id,
  input  wire signed [dps_pkg::PRIO_W-1:0] next_prio,
  input  wire [SLICE_BITS-1:0]             next_need,
  input  wire [SLICE_BITS-1:0]             next_used,
  output logic                             ge,
  output logic [dps_pkg::ID_W-1:0]         id,
  output logic signed [dps_pkg::PRIO_W-1:0] prio,
  output logic [SLICE_BITS-1:0]            need,
  output logic [SLICE_BITS-1:0]            used
);
  import dps_pkg::*;

  // A queued task with equal or higher priority stays ahead of the new one.
  assign ge = occ && ($signed(prio) >= $signed(cmd.prio));

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_INSERT: begin
        if (!ge) begin
          if (prev_ge) begin
            id   <= cmd.id;
            prio <= cmd.prio;
            need <= cmd_need;
            used <= cmd_used;
          end else begin
            id   <= prev_id;
            prio <= prev_prio;
            need <= prev_need;
            used <= prev_used;
          end
        end
      end
      OP_POP: begin
        id   <= next_id;
        prio <= next_prio;
        need <= next_need;
        used <= next_used;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/dynamic_priority_scheduler.sv -----
// Top level of the dynamic priority scheduler: control, result register and cell chain.
// Depends on dps_pkg, dps_req_if, dps_rsp_if and dps_cell.
//
//   Channel  Role    Payload
//   req      sink    req_type, task_id, priority_req, need_slices
//   rsp      source  status, ran_id, ran_priority, used_slices, finished, queue_length
//
// A run that puts its task back passes through the S_REINS state, which reinserts it
// into the chain; no request is taken in that state.
// The result is registered in the transfer cycle; a new request is taken while the
// result register is empty or is being emptied in the same cycle.
// Reset empties the queue and the result register.
`default_nettype none

module dynamic_priority_scheduler #(
  parameter int MAX_TASKS  = 16,
  parameter int SLICE_BITS = 8
) (
  input  wire        clk,
  input  wire        rst,
  dps_req_if.sink    req,
  dps_rsp_if.source  rsp
);
  import dps_pkg::*;

  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_REINS = 1'b1;

  logic                     state;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;

  logic [ID_W-1:0]          rq_id;
  logic signed [PRIO_W-1:0] rq_prio;
  logic [SLICE_BITS-1:0]    rq_need;
  logic [SLICE_BITS-1:0]    rq_used;

  logic [STATUS_W-1:0]      out_status;
  logic [ID_W-1:0]          out_id;
  logic signed [PRIO_W-1:0] out_prio;
  logic [USED_W-1:0]        out_used;
  logic                     out_fin;
  logic [CNT_W-1:0]         out_qlen;
  logic                     out_valid;

  logic [ID_W-1:0]          c_id   [MAX_TASKS];
  logic signed [PRIO_W-1:0] c_prio [MAX_TASKS];
  logic [SLICE_BITS-1:0]    c_need [MAX_TASKS];
  logic [SLICE_BITS-1:0]    c_used [MAX_TASKS];
  logic [MAX_TASKS-1:0]     c_ge;

  chain_cmd_t               cmd;
  logic [SLICE_BITS-1:0]    cmd_need;
  logic [SLICE_BITS-1:0]    cmd_used;

  logic                     acc;
  logic                     full;
  logic                     empty;
  logic [SLICE_BITS-1:0]    used_inc;
  logic                     fin;
  logic signed [PRIO_W-1:0] prio_dec;

  assign full  = (count == CNT_W'(MAX_TASKS));
  assign empty = (count == '0);

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign acc       = req.valid && req.ready;

  // Head of the queue, as it stands before a run.
  assign used_inc = (c_used[0] == '1) ? c_used[0] : c_used[0] + 1'b1;
  assign fin      = (used_inc >= c_need[0]);
  assign prio_dec = (c_prio[0] == PRIO_MIN) ? c_prio[0] : c_prio[0] - 8'sd1;

  always_comb begin
    cmd.op   = OP_HOLD;
    cmd.id   = req.task_id;
    cmd.prio = req.priority_req;
    cmd_need = SLICE_BITS'(req.need_slices);
    cmd_used = '0;
    count_next = count;
    if (state == S_REINS) begin
      cmd.op     = OP_INSERT;
      cmd.id     = rq_id;
      cmd.prio   = rq_prio;
      cmd_need   = rq_need;
      cmd_used   = rq_used;
      count_next = count + 1'b1;
    end else if (acc) begin
      if (req.req_type == REQ_ADD) begin
        if (!full) begin
          cmd.op     = OP_INSERT;
          count_next = count + 1'b1;
        end
      end else if (!empty) begin
        cmd.op     = OP_POP;
        count_next = count - 1'b1;
      end
    end
  end

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    localparam int PI = (i == 0) ? 0 : i - 1;
    localparam int NI = (i == MAX_TASKS - 1) ? i : i + 1;

    dps_cell #(
      .SLICE_BITS (SLICE_BITS)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .cmd_need  (cmd_need),
      .cmd_used  (cmd_used),
      .occ       (CNT_W'(i) < count),
      .prev_ge   ((i == 0) ? 1'b1 : c_ge[PI]),
      .prev_id   (c_id[PI]),
      .prev_prio (c_prio[PI]),
      .prev_need (c_need[PI]),
      .prev_used (c_used[PI]),
      .next_id   (c_id[NI]),
      .next_prio (c_prio[NI]),
      .next_need (c_need[NI]),
      .next_used (c_used[NI]),
      .ge        (c_ge[i]),
      .id        (c_id[i]),
      .prio      (c_prio[i]),
      .need      (c_need[i]),
      .used      (c_used[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      count <= count_next;
      if (state == S_REINS) begin
        state <= S_IDLE;
      end else if (acc && (req.req_type == REQ_RUN) && !empty && !fin) begin
        state <= S_REINS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rq_id   <= c_id[0];
      rq_prio <= prio_dec;
      rq_need <= c_need[0];
      rq_used <= used_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_id   <= '0;
      out_prio <= '0;
      out_used <= '0;
      out_fin  <= 1'b0;
      if (req.req_type == REQ_ADD) begin
        if (full) begin
          out_status <= ST_REJECTED;
          out_qlen   <= count;
        end else begin
          out_status <= ST_ADDED;
          out_qlen   <= count + 1'b1;
        end
      end else if (empty) begin
        out_status <= ST_IDLE;
        out_qlen   <= '0;
      end else begin
        out_status <= ST_RAN;
        out_id     <= c_id[0];
        out_prio   <= c_prio[0];
        out_used   <= USED_W'(used_inc);
        out_fin    <= fin;
        out_qlen   <= fin ? count - 1'b1 : count;
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.ran_id       = out_id;
  assign rsp.ran_priority = out_prio;
  assign rsp.used_slices  = out_used;
  assign rsp.finished     = out_fin;
  assign rsp.queue_length = out_qlen;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for dynamic_priority_scheduler: directed and random add/run requests.
// A scoreboard class predicts every result from its own copy of the ready queue.
// Depends on dps_pkg, dps_req_if, dps_rsp_if and the scheduler RTL.
`default_nettype none

module tb_top;
  import dps_pkg::*;

  localparam int MAX_TASKS    = 16;
  localparam int SLICE_BITS   = 8;
  localparam int QLEN_W       = 5;
  localparam int RANDOM_ITEMS = 880;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 150;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [PRIO_W-1:0] prio;
    logic [NEED_W-1:0]        need;
    logic [USED_W-1:0]        used;
  } waiting_task_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [ID_W-1:0]          ran_id;
    logic signed [PRIO_W-1:0] ran_priority;
    logic [USED_W-1:0]        used_slices;
    logic                     finished;
    logic [QLEN_W-1:0]        queue_length;
  } sched_result_t;

  class sched_scoreboard;
    waiting_task_t ready_tasks[$];
    sched_result_t expected_results[$];
    int            errors;

    function new();
      errors = 0;
    endfunction

    function void insert_by_priority(waiting_task_t t);
      int pos;
      pos = 0;
      while (pos < ready_tasks.size() && $signed(ready_tasks[pos].prio) >= $signed(t.prio))
        pos++;
      ready_tasks.insert(pos, t);
    endfunction

    function void note_request(logic rt, logic [ID_W-1:0] id, logic signed [PRIO_W-1:0] prio,
                               logic [NEED_W-1:0] need);
      waiting_task_t t;
      sched_result_t r;
      r = '0;
      if (rt == REQ_ADD) begin
        if (ready_tasks.size() >= MAX_TASKS) begin
          r.status = ST_REJECTED;
        end else begin
          t.id   = id;
          t.prio = prio;
          t.need = need;
          t.used = '0;
          insert_by_priority(t);
          r.status = ST_ADDED;
        end
      end else if (ready_tasks.size() == 0) begin
        r.status = ST_IDLE;
      end else begin
        t = ready_tasks.pop_front();
        r.status       = ST_RAN;
        r.ran_id       = t.id;
        r.ran_priority = t.prio;
        if (t.used != '1) t.used = t.used + 1'b1;
        r.used_slices = t.used;
        if (t.used >= t.need) begin
          r.finished = 1'b1;
        end else begin
          if (t.prio != PRIO_MIN) t.prio = t.prio - 8'sd1;
          insert_by_priority(t);
        end
      end
      r.queue_length = QLEN_W'(ready_tasks.size());
      expected_results.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t exp;
      if (expected_results.size() == 0) begin
        $error("Result transfer arrived with no request outstanding.");
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.status != exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.ran_id != exp.ran_id) begin
        $error("ran_id: expected %0d, got %0d", exp.ran_id, got.ran_id);
        errors++;
      end
      if (got.ran_priority != exp.ran_priority) begin
        $error("ran_priority: expected %0d, got %0d", $signed(exp.ran_priority),
               $signed(got.ran_priority));
        errors++;
      end
      if (got.used_slices != exp.used_slices) begin
        $error("used_slices: expected %0d, got %0d", exp.used_slices, got.used_slices);
        errors++;
      end
      if (got.finished != exp.finished) begin
        $error("finished: expected %0d, got %0d", exp.finished, got.finished);
        errors++;
      end
      if (got.queue_length != exp.queue_length) begin
        $error("queue_length: expected %0d, got %0d", exp.queue_length, got.queue_length);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   hold_rsp;
  bit   quiet;
  int   stall_cycles;
  sched_scoreboard sb;

  dps_req_if                   req_ch ();
  dps_rsp_if #(.QLEN_W(QLEN_W)) rsp_ch ();

  dynamic_priority_scheduler #(
    .MAX_TASKS  (MAX_TASKS),
    .SLICE_BITS (SLICE_BITS)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_request(input logic rt, input logic [ID_W-1:0] id,
                              input logic signed [PRIO_W-1:0] prio,
                              input logic [NEED_W-1:0] need);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= rt;
    req_ch.task_id      <= id;
    req_ch.priority_req <= prio;
    req_ch.need_slices  <= need;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  always @(posedge clk) begin : monitor
    sched_result_t got;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status       = rsp_ch.status;
        got.ran_id       = rsp_ch.ran_id;
        got.ran_priority = rsp_ch.ran_priority;
        got.used_slices  = rsp_ch.used_slices;
        got.finished     = rsp_ch.finished;
        got.queue_length = rsp_ch.queue_length;
        sb.check_result(got);
      end
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.req_type, req_ch.task_id, req_ch.priority_req,
                        req_ch.need_slices);
    end
  end

  initial begin
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    int                       add_pct;
    int                       phase_left;
    int                       pick;
    logic signed [PRIO_W-1:0] prio;
    logic [NEED_W-1:0]        need;
    sb = new();
    hold_rsp = 1'b0;
    quiet    = 1'b0;
    add_pct    = 50;
    phase_left = 0;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_ADD;
    req_ch.task_id      = '0;
    req_ch.priority_req = '0;
    req_ch.need_slices  = '0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty queue, zero need, priority floor, ties, then a full queue and a rejection.
    send_request(REQ_RUN, 4'd0, 8'sd0, 8'd0);
    send_request(REQ_ADD, 4'd0, 8'sd127, 8'd0);
    send_request(REQ_RUN, 4'hF, -8'sd1, 8'hFF);
    send_request(REQ_ADD, 4'd15, PRIO_MIN, 8'd2);
    send_request(REQ_RUN, 4'd0, 8'sd0, 8'd0);
    send_request(REQ_RUN, 4'd0, 8'sd0, 8'd0);
    send_request(REQ_ADD, 4'd1, 8'sd5, 8'd1);
    send_request(REQ_ADD, 4'd2, 8'sd5, 8'd1);
    send_request(REQ_ADD, 4'd3, 8'sd6, 8'd1);
    for (int i = 0; i < 13; i++)
      send_request(REQ_ADD, 4'(i + 4), (i % 4 == 0) ? 8'sd5 : 8'(i * 37 - 100),
                   (i == 5) ? 8'hFF : 8'(i % 3));
    send_request(REQ_ADD, 4'd9, 8'sd127, 8'd1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0: add_pct = 75;
          1: add_pct = 25;
          default: add_pct = 50;
        endcase
      end
      phase_left--;
      if (n == 300) hold_rsp = 1'b1;
      if (n == 600) begin
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.expected_results.size() != 0);
      end
      if (n == RANDOM_ITEMS - 100) quiet = 1'b1;

      pick = $urandom_range(0, 9);
      if (pick < 4)
        prio = PRIO_W'($urandom_range(0, 8) - 4);
      else if (pick < 6)
        prio = PRIO_W'(PRIO_MIN + $urandom_range(0, 4));
      else if (pick < 7)
        prio = PRIO_W'(8'sd127 - $urandom_range(0, 3));
      else
        prio = PRIO_W'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 80)
        need = NEED_W'($urandom_range(0, 4));
      else if (pick < 95)
        need = NEED_W'($urandom_range(0, 15));
      else
        need = NEED_W'($urandom_range(0, 255));

      send_request(($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_RUN,
                   ID_W'($urandom_range(0, 15)), prio, need);
    end

    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_results.size() != 0);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

`default_nettype wire
